// ===== rtl/sbph_pkg.sv =====
// Shared types, constants and a lookup function of the spectrum bar peak-hold meter.
package sbph_pkg;

   localparam int MAX_COLUMNS_DEFAULT = 64;

   localparam int COLUMN_W     = 8;
   localparam int LEVEL_W      = 8;
   localparam int ROW_W        = 6;
   localparam int KIND_W       = 2;
   localparam int PAL_W        = 8;
   localparam int RGB_W        = 24;
   localparam int WIDTH_REG_W  = 7;
   localparam int HEIGHT_REG_W = 6;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 24;
   localparam int HOLD_W       = 4;
   localparam int RECIP_W      = 9;
   localparam int DIV_STEPS    = 8;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET      = 7'd64;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET     = 6'd32;
   localparam logic [RGB_W-1:0]        COLOR_RESET      = 24'h000000;
   localparam logic [RGB_W-1:0]        DEFAULT_PEAK_RGB = 24'h00FF00;
   localparam logic [HOLD_W-1:0]       HOLD_NEW_PEAK    = 4'd15;
   localparam logic [HOLD_W-1:0]       HOLD_DECAY       = 4'd5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATRIX_WIDTH  = 2'd0,
      CSR_MATRIX_HEIGHT = 2'd1,
      CSR_PEAK_COLOR    = 2'd2
   } csr_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_OFF  = 2'd0,
      KIND_BAR  = 2'd1,
      KIND_PEAK = 2'd2
   } pixel_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_BARS,
      ST_NEWPEAK,
      ST_HOLD,
      ST_DECAY,
      ST_FLUSH
   } seq_state_type;

   typedef struct packed {
      logic [ROW_W-1:0]  bar;
      logic [ROW_W-1:0]  peak;
      logic [HOLD_W-1:0] hold;
   } col_state_type;

   typedef struct packed {
      logic [ROW_W-1:0] x;
      logic [ROW_W-1:0] y;
      pixel_kind_type   kind;
      logic [PAL_W-1:0] pal;
      logic [RGB_W-1:0] rgb;
   } pixel_type;

   typedef struct packed {
      logic      push;
      logic      flush;
      pixel_type pix;
   } wr_ctrl_type;

   // floor(256 / n); zero maps to zero
   function automatic logic [RECIP_W-1:0] recip256(input logic [5:0] n);
      logic [RECIP_W-1:0] r;
      case (n) inside
         6'd0:           r = 9'd0;
         6'd1:           r = 9'd256;
         6'd2:           r = 9'd128;
         6'd3:           r = 9'd85;
         6'd4:           r = 9'd64;
         6'd5:           r = 9'd51;
         6'd6:           r = 9'd42;
         6'd7:           r = 9'd36;
         6'd8:           r = 9'd32;
         6'd9:           r = 9'd28;
         6'd10:          r = 9'd25;
         6'd11:          r = 9'd23;
         6'd12:          r = 9'd21;
         6'd13:          r = 9'd19;
         6'd14:          r = 9'd18;
         6'd15:          r = 9'd17;
         6'd16:          r = 9'd16;
         6'd17:          r = 9'd15;
         6'd18:          r = 9'd14;
         6'd19:          r = 9'd13;
         [6'd20:6'd21]:  r = 9'd12;
         [6'd22:6'd23]:  r = 9'd11;
         [6'd24:6'd25]:  r = 9'd10;
         [6'd26:6'd28]:  r = 9'd9;
         [6'd29:6'd32]:  r = 9'd8;
         [6'd33:6'd36]:  r = 9'd7;
         [6'd37:6'd42]:  r = 9'd6;
         [6'd43:6'd51]:  r = 9'd5;
         default:        r = 9'd4;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/spectrum_bar_peak_hold.sv =====
// Top level of the peak-hold bar-graph meter: registers, sequencer, memory, divider, output.
//
// Request channel (req_*): one beat per spectrum sample, a column number and an RGB
// level. req_stall is low only while the block is idle; one sample is worked at a time.
// Response channel (rsp_*): one beat per pixel write for the matrix driver; the final
// write caused by a sample carries rsp_last_write. A sample that causes no write
// produces no beat.
// Per sample: a column at or beyond the width, or at or beyond MAX_COLUMNS, is skipped
// with no write. Otherwise the block reads the column state and starts the level
// divider, waits for the quotient, then makes one candidate write per cycle while the
// output has room (one per row the bar rises or falls, then the peak writes), then
// writes the state back. The divider and the single memory port set the time per sample.
// Reset clears all column state at once (per-entry valid bits) and restores width 64,
// height 32 and peak colour green. No clearing pass is needed.
// rsp_stall holds the output beat; one more write is buffered internally, and the
// sequencer waits when both are full. Configuration writes are taken on any cycle,
// but must only be issued while the block is idle.
module spectrum_bar_peak_hold #(
   parameter int MAX_COLUMNS = sbph_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sbph_pkg::COLUMN_W-1:0]        req_column,
   input  logic [sbph_pkg::LEVEL_W-1:0]         req_level_red,
   input  logic [sbph_pkg::LEVEL_W-1:0]         req_level_green,
   input  logic [sbph_pkg::LEVEL_W-1:0]         req_level_blue,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sbph_pkg::ROW_W-1:0]           rsp_pixel_x,
   output logic [sbph_pkg::ROW_W-1:0]           rsp_pixel_y,
   output logic [sbph_pkg::KIND_W-1:0]          rsp_pixel_kind,
   output logic [sbph_pkg::PAL_W-1:0]           rsp_palette_position,
   output logic [sbph_pkg::RGB_W-1:0]           rsp_pixel_rgb,
   output logic                                 rsp_last_write,
   input  logic                                 csr_write,
   input  logic [sbph_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sbph_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int COL_W = $clog2(MAX_COLUMNS);

   logic [sbph_pkg::WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [sbph_pkg::HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [sbph_pkg::RGB_W-1:0]        color_ff, color_in;
   logic [sbph_pkg::RGB_W-1:0]        peak_rgb;

   logic                              div_start;
   logic [sbph_pkg::LEVEL_W-1:0]      div_dividend;
   logic [sbph_pkg::RECIP_W-1:0]      div_divisor;
   logic                              div_done;
   logic [sbph_pkg::LEVEL_W-1:0]      div_quotient;
   logic                              mem_rd_en;
   logic                              mem_wr_en;
   logic [COL_W-1:0]                  mem_addr;
   sbph_pkg::col_state_type           mem_wr_data;
   sbph_pkg::col_state_type           mem_rd_data;
   sbph_pkg::wr_ctrl_type             wr_ctrl;
   logic                              out_room;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      color_in  = color_ff;
      if (csr_write) begin
         unique case (csr_index)
            sbph_pkg::CSR_MATRIX_WIDTH:  width_in  = csr_data[sbph_pkg::WIDTH_REG_W-1:0];
            sbph_pkg::CSR_MATRIX_HEIGHT: height_in = csr_data[sbph_pkg::HEIGHT_REG_W-1:0];
            sbph_pkg::CSR_PEAK_COLOR:    color_in  = csr_data[sbph_pkg::RGB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sbph_pkg::WIDTH_RESET;
         height_ff <= sbph_pkg::HEIGHT_RESET;
         color_ff  <= sbph_pkg::COLOR_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         color_ff  <= color_in;
      end
   end

   assign peak_rgb = (color_ff == '0) ? sbph_pkg::DEFAULT_PEAK_RGB : color_ff;

   sbph_seq #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_column      (req_column),
      .req_level_red   (req_level_red),
      .req_level_green (req_level_green),
      .req_level_blue  (req_level_blue),
      .cfg_width       (width_ff),
      .cfg_height      (height_ff),
      .cfg_peak_rgb    (peak_rgb),
      .div_start       (div_start),
      .div_dividend    (div_dividend),
      .div_divisor     (div_divisor),
      .div_done        (div_done),
      .div_quotient    (div_quotient),
      .mem_rd_en       (mem_rd_en),
      .mem_wr_en       (mem_wr_en),
      .mem_addr        (mem_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_data     (mem_rd_data),
      .wr_ctrl         (wr_ctrl),
      .out_room        (out_room)
   );

   sbph_state_mem #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_state_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .wr_en   (mem_wr_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   sbph_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   sbph_out_stage u_out_stage (
      .clock                (clock),
      .reset                (reset),
      .wr_ctrl              (wr_ctrl),
      .out_room             (out_room),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pixel_x          (rsp_pixel_x),
      .rsp_pixel_y          (rsp_pixel_y),
      .rsp_pixel_kind       (rsp_pixel_kind),
      .rsp_palette_position (rsp_palette_position),
      .rsp_pixel_rgb        (rsp_pixel_rgb),
      .rsp_last_write       (rsp_last_write)
   );

endmodule

// ===== rtl/sbph_state_mem.sv =====
// Per-column state memory with reset-cleared valid bits and registered read.
module sbph_state_mem #(
   parameter int MAX_COLUMNS = sbph_pkg::MAX_COLUMNS_DEFAULT,
   localparam int COL_W = $clog2(MAX_COLUMNS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic                  wr_en,
   input  logic [COL_W-1:0]      addr,
   input  sbph_pkg::col_state_type wr_data,
   output sbph_pkg::col_state_type rd_data
);

   sbph_pkg::col_state_type mem [MAX_COLUMNS];
   logic [MAX_COLUMNS-1:0]  valid_ff;
   sbph_pkg::col_state_type rd_q_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

// ===== rtl/sbph_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module sbph_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sbph_pkg::LEVEL_W-1:0]   dividend,
   input  logic [sbph_pkg::RECIP_W-1:0]   divisor,
   output logic                           done,
   output logic [sbph_pkg::LEVEL_W-1:0]   quotient
);

   logic [sbph_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [sbph_pkg::LEVEL_W-1:0]   rem_ff, rem_in;
   logic [sbph_pkg::LEVEL_W-1:0]   dq_ff, dq_in;
   logic [sbph_pkg::RECIP_W-1:0]   dvs_ff, dvs_in;
   logic [sbph_pkg::RECIP_W-1:0]   trial;
   logic [sbph_pkg::RECIP_W-1:0]   diff;
   logic                           ge;

   assign trial = {rem_ff, dq_ff[sbph_pkg::LEVEL_W-1]};
   assign ge    = trial >= dvs_ff;
   assign diff  = trial - dvs_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in = sbph_pkg::DIV_CNT_W'(sbph_pkg::DIV_STEPS);
         rem_in = '0;
         dq_in  = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = cnt_ff == sbph_pkg::DIV_CNT_W'(1);
         rem_in  = ge ? diff[sbph_pkg::LEVEL_W-1:0] : trial[sbph_pkg::LEVEL_W-1:0];
         dq_in   = {dq_ff[sbph_pkg::LEVEL_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

// ===== rtl/sbph_out_stage.sv =====
// Pending-write buffer and output register of the pixel write channel.
module sbph_out_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  sbph_pkg::wr_ctrl_type         wr_ctrl,
   output logic                          out_room,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sbph_pkg::ROW_W-1:0]    rsp_pixel_x,
   output logic [sbph_pkg::ROW_W-1:0]    rsp_pixel_y,
   output logic [sbph_pkg::KIND_W-1:0]   rsp_pixel_kind,
   output logic [sbph_pkg::PAL_W-1:0]    rsp_palette_position,
   output logic [sbph_pkg::RGB_W-1:0]    rsp_pixel_rgb,
   output logic                          rsp_last_write
);

   logic                pend_valid_ff, pend_valid_in;
   sbph_pkg::pixel_type pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sbph_pkg::pixel_type rsp_pix_ff, rsp_pix_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                out_free;
   logic                move;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign move     = pend_valid_ff && out_free && (wr_ctrl.push || wr_ctrl.flush);
   assign out_room = !pend_valid_ff || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (wr_ctrl.push) begin
         pend_valid_in = 1'b1;
         pend_in       = wr_ctrl.pix;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pix_in   = rsp_pix_ff;
      rsp_last_in  = rsp_last_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_pix_in   = pend_ff;
         rsp_last_in  = wr_ctrl.flush;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pixel_x          = rsp_pix_ff.x;
   assign rsp_pixel_y          = rsp_pix_ff.y;
   assign rsp_pixel_kind       = rsp_pix_ff.kind;
   assign rsp_palette_position = rsp_pix_ff.pal;
   assign rsp_pixel_rgb        = rsp_pix_ff.rgb;
   assign rsp_last_write       = rsp_last_ff;

endmodule

// ===== rtl/sbph_seq.sv =====
// Column sequencer: read state, scale level, walk bar and peak writes, write back.
module sbph_seq #(
   parameter int MAX_COLUMNS = sbph_pkg::MAX_COLUMNS_DEFAULT,
   localparam int COL_W = $clog2(MAX_COLUMNS)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sbph_pkg::COLUMN_W-1:0]       req_column,
   input  logic [sbph_pkg::LEVEL_W-1:0]        req_level_red,
   input  logic [sbph_pkg::LEVEL_W-1:0]        req_level_green,
   input  logic [sbph_pkg::LEVEL_W-1:0]        req_level_blue,
   input  logic [sbph_pkg::WIDTH_REG_W-1:0]    cfg_width,
   input  logic [sbph_pkg::HEIGHT_REG_W-1:0]   cfg_height,
   input  logic [sbph_pkg::RGB_W-1:0]          cfg_peak_rgb,
   output logic                                div_start,
   output logic [sbph_pkg::LEVEL_W-1:0]        div_dividend,
   output logic [sbph_pkg::RECIP_W-1:0]        div_divisor,
   input  logic                                div_done,
   input  logic [sbph_pkg::LEVEL_W-1:0]        div_quotient,
   output logic                                mem_rd_en,
   output logic                                mem_wr_en,
   output logic [COL_W-1:0]                    mem_addr,
   output sbph_pkg::col_state_type             mem_wr_data,
   input  sbph_pkg::col_state_type             mem_rd_data,
   output sbph_pkg::wr_ctrl_type               wr_ctrl,
   input  logic                                out_room
);

   localparam int ROW_W = sbph_pkg::ROW_W;

   sbph_pkg::seq_state_type            state_ff, state_in;
   logic [sbph_pkg::COLUMN_W-1:0]      col_ff, col_in;
   logic [sbph_pkg::LEVEL_W-1:0]       mx_ff, mx_in;
   logic [sbph_pkg::RECIP_W-1:0]       step_ff, step_in;
   logic [sbph_pkg::PAL_W-1:0]         pal_ff, pal_in;
   logic [ROW_W-1:0]                   newh_ff, newh_in;
   logic [ROW_W-1:0]                   cur_ff, cur_in;
   logic [ROW_W-1:0]                   pkl_ff, pkl_in;
   logic [sbph_pkg::HOLD_W-1:0]        hold_ff, hold_in;
   logic [ROW_W-1:0]                   p_ff, p_in;

   logic [ROW_W-1:0]                   hu;
   logic [ROW_W-1:0]                   hu_m1;
   logic [ROW_W-1:0]                   half;
   logic                               col_skip;
   logic                               below_half;
   logic [sbph_pkg::COLUMN_W-1:0]      mult_a;
   logic [2*sbph_pkg::COLUMN_W-1:0]    prod;
   logic [sbph_pkg::PAL_W-1:0]         pal_calc;
   logic [ROW_W-1:0]                   q_clamp;
   logic [sbph_pkg::LEVEL_W-1:0]       max_rg;
   logic                               rising;
   logic                               bar_end;
   logic                               new_peak;
   logic [ROW_W-1:0]                   decay_pk;
   logic                               cand_valid;
   logic                               adv;
   logic                               flush;
   sbph_pkg::pixel_type                cand;

   assign hu       = (cfg_height == '0) ? ROW_W'(1) : cfg_height;
   assign hu_m1    = hu - ROW_W'(1);
   assign half     = cfg_width[sbph_pkg::WIDTH_REG_W-1:1];
   assign col_skip = (col_ff >= {1'b0, cfg_width}) ||
                     ({1'b0, col_ff} >= (sbph_pkg::COLUMN_W + 1)'(MAX_COLUMNS));

   assign below_half = col_ff < {2'b00, half};
   assign mult_a     = below_half ? col_ff : col_ff - {2'b00, half};
   assign prod       = mult_a * step_ff[sbph_pkg::PAL_W-1:0];
   assign pal_calc   = below_half ? ~prod[sbph_pkg::PAL_W-1:0] : prod[sbph_pkg::PAL_W-1:0];

   assign q_clamp  = (div_quotient > {2'b00, hu_m1}) ? hu_m1 : div_quotient[ROW_W-1:0];
   assign max_rg   = (req_level_red > req_level_green) ? req_level_red : req_level_green;

   assign rising   = newh_ff > cur_ff;
   assign bar_end  = rising ? (p_ff == newh_ff) : (p_ff == cur_ff);
   assign new_peak = rising && (newh_ff > pkl_ff);
   assign decay_pk = (pkl_ff > newh_ff) ? pkl_ff - ROW_W'(1) : pkl_ff;
   assign adv      = !cand_valid || out_room;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbph_pkg::ST_IDLE: begin
            if (req_valid) state_in = sbph_pkg::ST_READ;
         end
         sbph_pkg::ST_READ: begin
            state_in = col_skip ? sbph_pkg::ST_IDLE : sbph_pkg::ST_DIV;
         end
         sbph_pkg::ST_DIV: begin
            if (div_done) state_in = sbph_pkg::ST_BARS;
         end
         sbph_pkg::ST_BARS: begin
            if (newh_ff == cur_ff || (adv && bar_end)) state_in = sbph_pkg::ST_NEWPEAK;
         end
         sbph_pkg::ST_NEWPEAK: begin
            if (adv) state_in = sbph_pkg::ST_HOLD;
         end
         sbph_pkg::ST_HOLD: begin
            if (hold_ff != '0) begin
               state_in = sbph_pkg::ST_FLUSH;
            end else if (adv) begin
               state_in = (pkl_ff != '0) ? sbph_pkg::ST_DECAY : sbph_pkg::ST_FLUSH;
            end
         end
         sbph_pkg::ST_DECAY: begin
            if (adv) state_in = sbph_pkg::ST_FLUSH;
         end
         sbph_pkg::ST_FLUSH: begin
            if (out_room) state_in = sbph_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      div_start  = 1'b0;
      mem_rd_en  = 1'b0;
      mem_wr_en  = 1'b0;
      flush      = 1'b0;
      cand_valid = 1'b0;
      cand.x     = col_ff[ROW_W-1:0];
      cand.y     = '0;
      cand.kind  = sbph_pkg::KIND_OFF;
      cand.pal   = '0;
      cand.rgb   = '0;
      unique case (state_ff)
         sbph_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         sbph_pkg::ST_READ: begin
            mem_rd_en = !col_skip;
            div_start = !col_skip;
         end
         sbph_pkg::ST_DIV: begin
         end
         sbph_pkg::ST_BARS: begin
            if (newh_ff != cur_ff) begin
               cand_valid = (p_ff != '0) && (p_ff <= hu);
               cand.y     = hu - p_ff;
               cand.kind  = rising ? sbph_pkg::KIND_BAR : sbph_pkg::KIND_OFF;
               cand.pal   = rising ? pal_ff : '0;
            end
         end
         sbph_pkg::ST_NEWPEAK: begin
            cand_valid = new_peak;
            cand.y     = hu_m1 - newh_ff;
            cand.kind  = sbph_pkg::KIND_PEAK;
            cand.rgb   = cfg_peak_rgb;
         end
         sbph_pkg::ST_HOLD: begin
            if (hold_ff == '0) begin
               cand_valid = pkl_ff <= hu_m1;
               cand.y     = hu_m1 - pkl_ff;
            end
         end
         sbph_pkg::ST_DECAY: begin
            cand_valid = decay_pk <= hu_m1;
            cand.y     = hu_m1 - decay_pk;
            cand.kind  = sbph_pkg::KIND_PEAK;
            cand.rgb   = cfg_peak_rgb;
         end
         sbph_pkg::ST_FLUSH: begin
            mem_wr_en = 1'b1;
            flush     = 1'b1;
         end
      endcase
   end

   always_comb begin
      col_in  = col_ff;
      mx_in   = mx_ff;
      step_in = step_ff;
      pal_in  = pal_ff;
      newh_in = newh_ff;
      cur_in  = cur_ff;
      pkl_in  = pkl_ff;
      hold_in = hold_ff;
      p_in    = p_ff;
      case (state_ff)
         sbph_pkg::ST_IDLE: begin
            if (req_valid) begin
               col_in = req_column;
               mx_in  = (max_rg > req_level_blue) ? max_rg : req_level_blue;
            end
         end
         sbph_pkg::ST_READ: begin
            step_in = sbph_pkg::recip256(half);
         end
         sbph_pkg::ST_DIV: begin
            pal_in = pal_calc;
            if (div_done) begin
               newh_in = q_clamp;
               cur_in  = mem_rd_data.bar;
               pkl_in  = mem_rd_data.peak;
               hold_in = mem_rd_data.hold;
               p_in    = (q_clamp > mem_rd_data.bar) ? mem_rd_data.bar : q_clamp + ROW_W'(1);
            end
         end
         sbph_pkg::ST_BARS: begin
            if (newh_ff != cur_ff && adv && !bar_end) p_in = p_ff + ROW_W'(1);
         end
         sbph_pkg::ST_NEWPEAK: begin
            if (adv && new_peak) begin
               pkl_in  = newh_ff;
               hold_in = sbph_pkg::HOLD_NEW_PEAK;
            end
         end
         sbph_pkg::ST_HOLD: begin
            if (hold_ff != '0) begin
               hold_in = hold_ff - 1'b1;
            end else if (adv && pkl_ff == '0) begin
               hold_in = sbph_pkg::HOLD_DECAY;
            end
         end
         sbph_pkg::ST_DECAY: begin
            if (adv) begin
               pkl_in  = decay_pk;
               hold_in = sbph_pkg::HOLD_DECAY;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbph_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff  <= col_in;
      mx_ff   <= mx_in;
      step_ff <= step_in;
      pal_ff  <= pal_in;
      newh_ff <= newh_in;
      cur_ff  <= cur_in;
      pkl_ff  <= pkl_in;
      hold_ff <= hold_in;
      p_ff    <= p_in;
   end

   assign div_dividend     = mx_ff;
   assign div_divisor      = sbph_pkg::recip256(hu);
   assign mem_addr         = col_ff[COL_W-1:0];
   assign mem_wr_data.bar  = newh_ff;
   assign mem_wr_data.peak = pkl_ff;
   assign mem_wr_data.hold = hold_ff;
   assign wr_ctrl.push     = cand_valid && out_room;
   assign wr_ctrl.flush    = flush;
   assign wr_ctrl.pix      = cand;

endmodule

// ===== rtl/sbph_checker.sv =====
// Port-level checker for the peak-hold meter and its bind to the top level.
module sbph_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [sbph_pkg::ROW_W-1:0]          rsp_pixel_x,
   input logic [sbph_pkg::ROW_W-1:0]          rsp_pixel_y,
   input logic [sbph_pkg::KIND_W-1:0]         rsp_pixel_kind,
   input logic [sbph_pkg::PAL_W-1:0]          rsp_palette_position,
   input logic [sbph_pkg::RGB_W-1:0]          rsp_pixel_rgb,
   input logic                                rsp_last_write
);

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pixel_x) && $stable(rsp_pixel_y) &&
         $stable(rsp_pixel_kind) && $stable(rsp_palette_position) &&
         $stable(rsp_pixel_rgb) && $stable(rsp_last_write))
      else $error("response payload changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_bar_no_rgb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_kind == sbph_pkg::KIND_BAR |-> rsp_pixel_rgb == '0)
      else $error("bar pixel carries a direct colour");

   a_direct_no_palette: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_kind != sbph_pkg::KIND_BAR |-> rsp_palette_position == '0)
      else $error("off or peak pixel carries a palette position");

endmodule

bind spectrum_bar_peak_hold sbph_checker u_checker (.*);

// ===== tb/sv/tb_spectrum_bar_peak_hold.sv =====
// Self-checking testbench for spectrum_bar_peak_hold: directed and random samples checked against a per-column predictor.
module tb_spectrum_bar_peak_hold;
   timeunit 1ns;
   timeprecision 1ps;

   import sbph_pkg::*;

   localparam int N_COLUMNS     = MAX_COLUMNS_DEFAULT;
   localparam int MAX_WRITES    = 64;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_ITEMS   = 26;

   typedef struct {
      logic [ROW_W-1:0] x;
      logic [ROW_W-1:0] y;
      pixel_kind_type   kind;
      logic [PAL_W-1:0] pal;
      logic [RGB_W-1:0] rgb;
      logic             last;
   } pixel_write_t;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [COLUMN_W-1:0]    req_column;
   logic [LEVEL_W-1:0]     req_level_red;
   logic [LEVEL_W-1:0]     req_level_green;
   logic [LEVEL_W-1:0]     req_level_blue;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [ROW_W-1:0]       rsp_pixel_x;
   logic [ROW_W-1:0]       rsp_pixel_y;
   logic [KIND_W-1:0]      rsp_pixel_kind;
   logic [PAL_W-1:0]       rsp_palette_position;
   logic [RGB_W-1:0]       rsp_pixel_rgb;
   logic                   rsp_last_write;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   logic [WIDTH_REG_W-1:0]  cfg_width;
   logic [HEIGHT_REG_W-1:0] cfg_height;
   logic [RGB_W-1:0]        cfg_color;
   logic [ROW_W-1:0]        bar_mem [N_COLUMNS];
   logic [ROW_W-1:0]        peak_mem [N_COLUMNS];
   logic [HOLD_W-1:0]       hold_mem [N_COLUMNS];

   pixel_write_t pending_writes [$];
   int           sample_writes;
   int           failures;
   int           cycle_count;
   int           samples_sent;
   int           writes_checked;
   int           settings_written;
   bit           quiet;

   spectrum_bar_peak_hold #(.MAX_COLUMNS(N_COLUMNS)) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_column          (req_column),
      .req_level_red       (req_level_red),
      .req_level_green     (req_level_green),
      .req_level_blue      (req_level_blue),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_pixel_x         (rsp_pixel_x),
      .rsp_pixel_y         (rsp_pixel_y),
      .rsp_pixel_kind      (rsp_pixel_kind),
      .rsp_palette_position(rsp_palette_position),
      .rsp_pixel_rgb       (rsp_pixel_rgb),
      .rsp_last_write      (rsp_last_write),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void queue_write(int x, int y, int h, pixel_kind_type kind,
                                       logic [PAL_W-1:0] pal, logic [RGB_W-1:0] rgb);
      pixel_write_t w;
      if (y < 0 || y >= h || sample_writes >= MAX_WRITES) return;
      w.x    = ROW_W'(x);
      w.y    = ROW_W'(y);
      w.kind = kind;
      w.pal  = pal;
      w.rgb  = rgb;
      w.last = 1'b0;
      pending_writes.push_back(w);
      sample_writes++;
   endfunction

   function automatic void predict_sample(logic [COLUMN_W-1:0] col, logic [LEVEL_W-1:0] lr,
                                          logic [LEVEL_W-1:0] lg, logic [LEVEL_W-1:0] lb);
      int c, h, half, stp, mx, newh, cur, p;
      logic [PAL_W-1:0] pal;
      logic [RGB_W-1:0] pk;
      pixel_write_t     w;
      sample_writes = 0;
      c = int'(col);
      if (c >= int'(cfg_width) || c >= N_COLUMNS) return;
      h    = (cfg_height == 0) ? 1 : int'(cfg_height);
      half = int'(cfg_width) / 2;
      stp  = (half != 0) ? 256 / half : 0;
      pal  = (c < half) ? PAL_W'(255 - c * stp) : PAL_W'((c - half) * stp);
      pk   = (cfg_color != 0) ? cfg_color : DEFAULT_PEAK_RGB;
      mx = int'(lr);
      if (int'(lg) > mx) mx = int'(lg);
      if (int'(lb) > mx) mx = int'(lb);
      newh = mx / (256 / h);
      if (newh > h - 1) newh = h - 1;
      cur = int'(bar_mem[c]);
      if (newh > cur) begin
         for (p = cur; p <= newh; p++) queue_write(c, h - p, h, KIND_BAR, pal, '0);
         if (newh > int'(peak_mem[c])) begin
            hold_mem[c] = HOLD_NEW_PEAK;
            peak_mem[c] = ROW_W'(newh);
            queue_write(c, h - 1 - newh, h, KIND_PEAK, '0, pk);
         end
         bar_mem[c] = ROW_W'(newh);
      end else if (newh < cur) begin
         for (p = newh + 1; p <= cur; p++) queue_write(c, h - p, h, KIND_OFF, '0, '0);
         bar_mem[c] = ROW_W'(newh);
      end
      if (hold_mem[c] != 0) begin
         hold_mem[c] = hold_mem[c] - 1'b1;
      end else begin
         queue_write(c, h - 1 - int'(peak_mem[c]), h, KIND_OFF, '0, '0);
         if (peak_mem[c] != 0) begin
            if (peak_mem[c] > bar_mem[c]) peak_mem[c] = peak_mem[c] - 1'b1;
            queue_write(c, h - 1 - int'(peak_mem[c]), h, KIND_PEAK, '0, pk);
         end
         hold_mem[c] = HOLD_DECAY;
      end
      if (sample_writes > 0) begin
         w = pending_writes.pop_back();
         w.last = 1'b1;
         pending_writes.push_back(w);
      end
   endfunction

   function automatic void check_field(string name, logic [RGB_W-1:0] want,
                                       logic [RGB_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 32);
   end

   always @(posedge clock) begin : check_writes
      pixel_write_t due;
      cycle_count++;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_writes.size() == 0) begin
            $error("pixel write beat with none expected: x=%0d y=%0d kind=%0d",
                   rsp_pixel_x, rsp_pixel_y, rsp_pixel_kind);
            failures++;
         end else begin
            due = pending_writes.pop_front();
            check_field("pixel_x", due.x, rsp_pixel_x);
            check_field("pixel_y", due.y, rsp_pixel_y);
            check_field("pixel_kind", due.kind, rsp_pixel_kind);
            check_field("palette_position", due.pal, rsp_palette_position);
            check_field("pixel_rgb", due.rgb, rsp_pixel_rgb);
            check_field("last_write", due.last, rsp_last_write);
            writes_checked++;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("spectrum_bar_peak_hold regression: fail");
      $finish;
   end

   task automatic send_sample(input logic [COLUMN_W-1:0] col, input logic [LEVEL_W-1:0] lr,
                              input logic [LEVEL_W-1:0] lg, input logic [LEVEL_W-1:0] lb);
      while (!quiet && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_column      <= col;
      req_level_red   <= lr;
      req_level_green <= lg;
      req_level_blue  <= lb;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_sample(col, lr, lg, lb);
      samples_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MATRIX_WIDTH:  cfg_width  = value[WIDTH_REG_W-1:0];
         CSR_MATRIX_HEIGHT: cfg_height = value[HEIGHT_REG_W-1:0];
         CSR_PEAK_COLOR:    cfg_color  = value[RGB_W-1:0];
         default: ;
      endcase
      settings_written++;
   endtask

   task automatic test_reset_defaults();
      send_sample(8'd0, 8'd255, 8'd0, 8'd0);
      send_sample(8'd63, 8'd0, 8'd255, 8'd0);
      send_sample(8'd64, 8'd9, 8'd9, 8'd9);
      send_sample(8'd255, 8'd1, 8'd2, 8'd3);
      send_sample(8'd5, 8'd0, 8'd0, 8'd0);
      settle();
   endtask

   task automatic test_bar_motion();
      send_sample(8'd10, 8'd0, 8'd0, 8'd200);
      send_sample(8'd10, 8'd100, 8'd0, 8'd0);
      send_sample(8'd10, 8'd0, 8'd150, 8'd0);
      send_sample(8'd10, 8'd50, 8'd50, 8'd50);
      settle();
   endtask

   task automatic test_register_extremes();
      write_reg(CSR_MATRIX_WIDTH, 24'd2);
      write_reg(CSR_MATRIX_HEIGHT, 24'd1);
      write_reg(CSR_PEAK_COLOR, 24'hFFFFFF);
      send_sample(8'd0, 8'd255, 8'd255, 8'd255);
      send_sample(8'd1, 8'd0, 8'd128, 8'd0);
      send_sample(8'd2, 8'd77, 8'd0, 8'd0);
      settle();
      write_reg(CSR_MATRIX_HEIGHT, 24'd0);
      send_sample(8'd1, 8'd255, 8'd0, 8'd0);
      settle();
      write_reg(CSR_MATRIX_WIDTH, 24'd1);
      send_sample(8'd0, 8'd0, 8'd0, 8'd200);
      send_sample(8'd1, 8'd200, 8'd0, 8'd0);
      settle();
      write_reg(CSR_MATRIX_WIDTH, 24'd64);
      write_reg(CSR_MATRIX_HEIGHT, 24'd62);
      write_reg(CSR_PEAK_COLOR, 24'(($urandom_range(24'hFFFFFE)) + 1));
      send_sample(8'd0, 8'd255, 8'd0, 8'd0);
      settle();
   endtask

   task automatic test_height_shrink();
      write_reg(CSR_MATRIX_HEIGHT, 24'd62);
      send_sample(8'd3, 8'd255, 8'd0, 8'd0);
      send_sample(8'd2, 8'd0, 8'd0, 8'd240);
      settle();
      write_reg(CSR_MATRIX_HEIGHT, 24'd8);
      send_sample(8'd3, 8'd0, 8'd0, 8'd0);
      send_sample(8'd2, 8'd0, 8'd60, 8'd0);
      settle();
   endtask

   task automatic test_random_traffic();
      logic [COLUMN_W-1:0] col;
      logic [LEVEL_W-1:0]  lr, lg, lb;
      int                  phase, n, span, base;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_MATRIX_WIDTH, 24'd64);
               write_reg(CSR_MATRIX_HEIGHT, 24'd32);
               write_reg(CSR_PEAK_COLOR, 24'd0);
            end
            2: begin
               write_reg(CSR_MATRIX_WIDTH, 24'd2);
               write_reg(CSR_MATRIX_HEIGHT, 24'd62);
            end
            3: begin
               write_reg(CSR_MATRIX_WIDTH, 24'd64);
               write_reg(CSR_MATRIX_HEIGHT, 24'(($urandom_range(3)) + 1));
               write_reg(CSR_PEAK_COLOR, 24'hFFFFFF);
            end
            default: begin
               write_reg(CSR_MATRIX_WIDTH, 24'($urandom_range(64, 2)));
               write_reg(CSR_MATRIX_HEIGHT, 24'($urandom_range(62, 1)));
               write_reg(CSR_PEAK_COLOR, 24'($urandom_range(24'hFFFFFF)));
            end
         endcase
         quiet = (phase == 0);
         span  = (cfg_width < 8) ? int'(cfg_width) : 8;
         base  = $urandom_range(int'(cfg_width) - span);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(9) == 0) col = $urandom_range(255);
            else col = COLUMN_W'(base + $urandom_range(span - 1));
            lr = $urandom_range(255);
            lg = $urandom_range(255);
            lb = $urandom_range(255);
            case ($urandom_range(4))
               0: begin
                  lr = lr >> 4;
                  lg = lg >> 4;
                  lb = lb >> 4;
               end
               1: begin
                  lg = '0;
                  lb = '0;
               end
               2: lr = '0;
               default: ;
            endcase
            if (phase == 1 && n % 4 == 0 && pending_writes.size() != 0) begin
               req_valid <= 1'b0;
               while (pending_writes.size() != 0) @(posedge clock);
            end
            send_sample(col, lr, lg, lb);
         end
         settle();
         quiet = 1'b0;
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_column      <= '0;
      req_level_red   <= '0;
      req_level_green <= '0;
      req_level_blue  <= '0;
      rsp_stall       <= 1'b0;
      csr_write       <= 1'b0;
      csr_index       <= CSR_MATRIX_WIDTH;
      csr_data        <= '0;
      quiet           = 1'b0;
      failures        = 0;
      cycle_count     = 0;
      cfg_width       = WIDTH_RESET;
      cfg_height      = HEIGHT_RESET;
      cfg_color       = COLOR_RESET;
      for (int k = 0; k < N_COLUMNS; k++) begin
         bar_mem[k]  = '0;
         peak_mem[k] = '0;
         hold_mem[k] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_bar_motion();
      test_register_extremes();
      test_height_shrink();
      test_random_traffic();
      settle();
      $display("Sent %0d samples and checked %0d pixel writes across %0d register writes,",
               samples_sent, writes_checked, settings_written);
      $display("covering rising, falling and decaying bars, ignored columns and shrunk heights.");
      if (failures == 0) begin
         $display("spectrum_bar_peak_hold regression: pass");
      end else begin
         $display("spectrum_bar_peak_hold regression: fail");
      end
      $finish;
   end

endmodule
